[rtl/gqb_pkg.sv]
// ----------------------------------------------------------------------------
// gqb_pkg
// Shared types, constants and helpers for the gray quantize bit pack core.
// ----------------------------------------------------------------------------
package gqb_pkg;

  localparam int unsigned NumLanes = 3;

  typedef enum logic [1:0] {
    BITS_1,
    BITS_2,
    BITS_4,
    BITS_8
  } bits_sel_e;

  // register index codes, decoded from paddr[2]
  localparam logic REG_GRAY_MODE   = 1'b0;
  localparam logic REG_BITS_SELECT = 1'b1;

  localparam logic [17:0] LUMA_R    = 18'd213;
  localparam logic [17:0] LUMA_G    = 18'd715;
  localparam logic [17:0] LUMA_B    = 18'd72;
  localparam logic [17:0] LUMA_HALF = 18'd500;

  // x / 1000 == (x * 268436) >> 28 for x < 2^18
  localparam logic [36:0] LUMA_RECIP = 37'd268436;
  localparam int unsigned LumaShift  = 28;

  // x / 255 == (x * 4113) >> 20 for x < 4096
  localparam logic [11:0] QUANT_HALF  = 12'd127;
  localparam logic [24:0] QUANT_RECIP = 25'd4113;
  localparam int unsigned QuantShift  = 20;

  typedef struct packed {
    logic row_end;
    logic frame_end;
  } flags_t;

  typedef struct packed {
    logic [7:0] data;
    logic       row_last;
    logic       frame_last;
    logic       run_last;
  } out_ent_t;

  function automatic logic [3:0] bit_count(input bits_sel_e sel);
    logic [3:0] n;
    n = 4'd1 << sel;
    return n;
  endfunction

endpackage

[rtl/gqb_pix_if.sv]
// ----------------------------------------------------------------------------
// gqb_pix_if
// Pixel channel: one RGB pixel with row and frame markers per transfer.
// ----------------------------------------------------------------------------
interface gqb_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       row_end;
  logic       frame_end;

  modport source (output valid, red, green, blue, row_end, frame_end, input ready);
  modport sink   (input valid, red, green, blue, row_end, frame_end, output ready);
endinterface

[rtl/gqb_byte_if.sv]
// ----------------------------------------------------------------------------
// gqb_byte_if
// Byte channel: one packed byte with its end markers per transfer.
// ----------------------------------------------------------------------------
interface gqb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       row_last;
  logic       frame_last;
  logic       run_last;

  modport source (output valid, out_byte, row_last, frame_last, run_last, input ready);
  modport sink   (input valid, out_byte, row_last, frame_last, run_last, output ready);
endinterface

[rtl/gqb_lane.sv]
// ----------------------------------------------------------------------------
// gqb_lane
// One quantizer lane: (v * max + 127) / 255 at 1, 2 or 4 bits, pass at 8.
// ----------------------------------------------------------------------------
module gqb_lane (
  input  logic [7:0]         smp_i,
  input  gqb_pkg::bits_sel_e bsel_i,
  output logic [7:0]         q_o
);
  import gqb_pkg::*;

  logic [3:0]  nbits;
  logic [7:0]  qmax;
  logic [11:0] scaled;
  logic [24:0] prod;
  logic [7:0]  quot;

  always_comb begin
    nbits  = bit_count(bsel_i);
    qmax   = 8'((9'd1 << nbits) - 9'd1);
    scaled = (12'(smp_i) << nbits) - 12'(smp_i) + QUANT_HALF;
    prod   = 25'(scaled) * QUANT_RECIP;
    quot   = 8'(prod[24:QuantShift]);
    if (bsel_i == BITS_8) begin
      q_o = smp_i;
    end else begin
      q_o = quot & qmax;
    end
  end

endmodule

[rtl/gqb_pack.sv]
// ----------------------------------------------------------------------------
// gqb_pack
// Merges the lane samples into bytes, MSB first, and holds up to three
// finished bytes in a shift buffer draining one byte per cycle on out_ready_i.
// ----------------------------------------------------------------------------
module gqb_pack (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [7:0]         q_i [3],
  input  gqb_pkg::flags_t    flags_i,
  input  logic               gray_i,
  input  gqb_pkg::bits_sel_e bsel_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gqb_pkg::out_ent_t  out_ent_o
);
  import gqb_pkg::*;

  logic [3:0] bp_q, bp_d;
  logic [7:0] pb_q, pb_d;
  logic [1:0] cnt_q;
  out_ent_t   ent_q [3];
  out_ent_t   em [3];
  logic [1:0] k;
  logic [1:0] kl;
  logic [3:0] nbits;
  logic [15:0] sh;
  logic       row_done;
  logic       load;
  logic       pop;

  always_comb begin
    nbits    = bit_count(bsel_i);
    bp_d     = bp_q;
    pb_d     = pb_q;
    k        = '0;
    kl       = '0;
    sh       = '0;
    row_done = flags_i.row_end | flags_i.frame_end;
    for (int i = 0; i < NumLanes; i++) begin
      em[i] = '0;
    end
    for (int i = 0; i < NumLanes; i++) begin
      if (i == 0 || !gray_i) begin
        if (bp_d > 4'd8 || nbits > bp_d) begin
          bp_d = 4'd8;
          pb_d = '0;
        end
        if (bp_d == 4'd8) begin
          pb_d = '0;
        end
        bp_d = bp_d - nbits;
        sh   = 16'(q_i[i]) << bp_d;
        pb_d = pb_d | sh[7:0];
        if (bp_d == 4'd0) begin
          em[k].data = pb_d;
          k    = k + 2'd1;
          pb_d = '0;
          bp_d = 4'd8;
        end
      end
    end
    if (row_done && bp_d < 4'd8) begin
      em[k].data = pb_d;
      k    = k + 2'd1;
      pb_d = '0;
      bp_d = 4'd8;
    end
    if (k != 2'd0) begin
      kl = k - 2'd1;
      em[kl].row_last   = row_done;
      em[kl].frame_last = flags_i.frame_end;
      em[kl].run_last   = 1'b1;
    end
  end

  assign ready_o     = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready_i);
  assign load        = valid_i && ready_o;
  assign pop         = (cnt_q != 2'd0) && out_ready_i;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_ent_o   = ent_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_q  <= 4'd8;
      pb_q  <= '0;
      cnt_q <= '0;
    end else if (load) begin
      bp_q  <= bp_d;
      pb_q  <= pb_d;
      cnt_q <= k;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ent_q <= em;
    end else if (pop) begin
      ent_q[0] <= ent_q[1];
      ent_q[1] <= ent_q[2];
    end
  end

endmodule

[rtl/gray_quantize_bitpack_core.sv]
// ----------------------------------------------------------------------------
// gray_quantize_bitpack_core
// Luma or RGB quantize and bit pack of a pixel stream into bytes.
// ----------------------------------------------------------------------------
// pix_i takes one RGB pixel per transfer with row_end and frame_end markers;
// byte_o gives packed bytes, samples MSB first, with row_last, frame_last and
// run_last on the last byte of a pixel. gray_mode and bits_select are set
// over the APB port (0x0 and 0x4); the user must set them only while the core
// is idle, which the core itself has no check for. Pipeline: luma sum,
// divide by 1000, three quantizer lanes, then the packer; a pixel passes
// the stage 1, 2 and 3 registers and the output buffer before its first
// byte shows on byte_o. The packer loads one pixel's bytes (zero to three)
// into a three-entry output buffer and byte_o drains one byte per cycle while
// ready; the packer takes the next pixel once the buffer is empty or its last
// byte is taken: one pixel per cycle in gray mode while byte_o is ready,
// and 8-bit RGB bound by the byte-wide output. When byte_o stalls the buffer
// holds and the stall walks back through the pipeline registers to
// pix_i.ready; no data is dropped. Reset clears the pipeline, empties the
// byte being packed and sets gray_mode to 1 and bits_select to 8 bits.
// ----------------------------------------------------------------------------
module gray_quantize_bitpack_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  gqb_pix_if.sink     pix_i,
  gqb_byte_if.source  byte_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gqb_pkg::*;

  logic      gray_q;
  bits_sel_e bsel_q;
  logic      wr_en;

  logic        s1_v_q, s2_v_q, s3_v_q;
  logic        s1_ready, s2_ready, s3_ready, pack_ready;
  logic [17:0] s1_sum_q, sum_d;
  logic [7:0]  s1_rgb_q [3];
  flags_t      s1_flags_q, s2_flags_q, s3_flags_q;
  logic [36:0] luma_prod;
  logic [7:0]  smp_d [3];
  logic [7:0]  s2_smp_q [3];
  logic [7:0]  q_d [3];
  logic [7:0]  s3_q_q [3];
  out_ent_t    out_ent;

  // configuration
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gray_q <= 1'b1;
      bsel_q <= BITS_8;
    end else if (wr_en) begin
      case (paddr[2])
        REG_GRAY_MODE:   gray_q <= pwdata[0];
        REG_BITS_SELECT: bsel_q <= bits_sel_e'(pwdata[1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_GRAY_MODE:   prdata = {31'd0, gray_q};
      REG_BITS_SELECT: prdata = {30'd0, bsel_q};
      default:         prdata = '0;
    endcase
  end

  // pipeline handshake
  assign s3_ready    = !s3_v_q || pack_ready;
  assign s2_ready    = !s2_v_q || s3_ready;
  assign s1_ready    = !s1_v_q || s2_ready;
  assign pix_i.ready = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_ready) s1_v_q <= pix_i.valid;
      if (s2_ready) s2_v_q <= s1_v_q;
      if (s3_ready) s3_v_q <= s2_v_q;
    end
  end

  // stage 1: weighted luma sum
  assign sum_d = 18'(pix_i.red) * LUMA_R + 18'(pix_i.green) * LUMA_G
               + 18'(pix_i.blue) * LUMA_B + LUMA_HALF;

  always_ff @(posedge clk_i) begin
    if (s1_ready && pix_i.valid) begin
      s1_sum_q    <= sum_d;
      s1_rgb_q[0] <= pix_i.red;
      s1_rgb_q[1] <= pix_i.green;
      s1_rgb_q[2] <= pix_i.blue;
      s1_flags_q  <= '{row_end: pix_i.row_end, frame_end: pix_i.frame_end};
    end
  end

  // stage 2: divide by 1000, select samples
  assign luma_prod = 37'(s1_sum_q) * LUMA_RECIP;

  always_comb begin
    smp_d[0] = gray_q ? luma_prod[LumaShift +: 8] : s1_rgb_q[0];
    smp_d[1] = s1_rgb_q[1];
    smp_d[2] = s1_rgb_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_v_q) begin
      s2_smp_q   <= smp_d;
      s2_flags_q <= s1_flags_q;
    end
  end

  // stage 3: quantizer lanes
  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    gqb_lane u_lane (
      .smp_i  (s2_smp_q[i]),
      .bsel_i (bsel_q),
      .q_o    (q_d[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_v_q) begin
      s3_q_q     <= q_d;
      s3_flags_q <= s2_flags_q;
    end
  end

  // merge and output buffer
  gqb_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s3_v_q),
    .ready_o     (pack_ready),
    .q_i         (s3_q_q),
    .flags_i     (s3_flags_q),
    .gray_i      (gray_q),
    .bsel_i      (bsel_q),
    .out_valid_o (byte_o.valid),
    .out_ready_i (byte_o.ready),
    .out_ent_o   (out_ent)
  );

  assign byte_o.out_byte   = out_ent.data;
  assign byte_o.row_last   = out_ent.row_last;
  assign byte_o.frame_last = out_ent.frame_last;
  assign byte_o.run_last   = out_ent.run_last;

endmodule
